// ===== hw/rtl/key_value_list_tokenizer_assert.svh =====
// Assertion macros for the key/value list tokenizer.
`ifndef KEY_VALUE_LIST_TOKENIZER_ASSERT_SVH
`define KEY_VALUE_LIST_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define KVLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvlt assertion failed");
`define KVLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvlt assertion failed");
`else
`define KVLT_ASSERT_IMP(label, ante, cons)
`define KVLT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/kvlt_pkg.sv =====
// Types, codes and character classes of the key/value list tokenizer.
package kvlt_pkg;

  typedef enum logic [8:0] {
    PH_START     = 9'b000000001,
    PH_KEY_START = 9'b000000010,
    PH_KEY       = 9'b000000100,
    PH_AFTER_KEY = 9'b000001000,
    PH_AFTER_EQ  = 9'b000010000,
    PH_UNQUOTED  = 9'b000100000,
    PH_QUOTED    = 9'b001000000,
    PH_AFTER_VAL = 9'b010000000,
    PH_ERROR     = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_VALUE  = 3'd2,
    KIND_PAIR   = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_REJECT = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_KEY_START = 2'd0,
    ERR_EQUALS    = 2'd1,
    ERR_QUOTE     = 2'd2,
    ERR_CONTENT   = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    err_t       err;
  } result_t;

  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

endpackage

// ===== hw/rtl/key_value_list_tokenizer.sv =====
// Key/value list tokenizer: byte stream in, tagged token stream out.
//
// Accepts one text byte per cycle while the output is not stalled and no second
// result is pending. The result for a byte passes through the input register,
// then the result register. An end-of-text transaction gives the verdict. When a
// pair is still open, it first gives a pair-complete result and then the
// verdict. While the second result waits to go out, the input side stalls, and
// it stalls longer while out_tready is low. The parse state machine updates once
// per transaction; end of text returns it to the start.
module key_value_list_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [9:8] error_code, [15:10] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last_of_run
);
  import kvlt_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  phase_t     phase_r, phase_nxt;
  logic       quote_r, quote_nxt;
  err_t       err_r, err_nxt;

  logic       out_v_r;
  result_t    out_res_r;
  logic       out_last_r;
  logic       pend_v_r;

  result_t    res0;
  logic       two;
  logic       fire;

  assign fire      = in_v_r && !pend_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  always_comb begin
    res0      = '{kind: KIND_NONE, ch: 8'd0, err: ERR_KEY_START};
    two       = 1'b0;
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    err_nxt   = err_r;
    if (in_eot_r) begin
      phase_nxt = PH_START;
      quote_nxt = 1'b0;
      err_nxt   = ERR_KEY_START;
      case (phase_r)
        PH_KEY_START: begin
          res0.kind = KIND_REJECT;
          res0.err  = ERR_KEY_START;
        end
        PH_KEY, PH_AFTER_KEY: begin
          res0.kind = KIND_REJECT;
          res0.err  = ERR_EQUALS;
        end
        PH_QUOTED: begin
          res0.kind = KIND_REJECT;
          res0.err  = ERR_QUOTE;
        end
        PH_AFTER_EQ, PH_UNQUOTED, PH_AFTER_VAL: begin
          res0.kind = KIND_PAIR;
          two       = 1'b1;
        end
        PH_ERROR: begin
          res0.kind = KIND_REJECT;
          res0.err  = err_r;
        end
        default: begin
          res0.kind = KIND_ACCEPT;
        end
      endcase
    end else begin
      case (phase_r)
        PH_KEY: begin
          if (is_alnum(in_byte_r) || in_byte_r == CH_DASH || in_byte_r == CH_UNDER) begin
            res0.kind = KIND_KEY;
            res0.ch   = in_byte_r;
          end else if (is_ws(in_byte_r)) begin
            phase_nxt = PH_AFTER_KEY;
          end else if (in_byte_r == CH_EQUALS) begin
            phase_nxt = PH_AFTER_EQ;
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_EQUALS;
          end
        end
        PH_AFTER_KEY: begin
          if (in_byte_r == CH_EQUALS) begin
            phase_nxt = PH_AFTER_EQ;
          end else if (!is_ws(in_byte_r)) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_EQUALS;
          end
        end
        PH_AFTER_EQ: begin
          if (in_byte_r == CH_DQUOTE || in_byte_r == CH_SQUOTE) begin
            quote_nxt = (in_byte_r == CH_SQUOTE);
            phase_nxt = PH_QUOTED;
          end else if (in_byte_r == CH_COMMA) begin
            res0.kind = KIND_PAIR;
            phase_nxt = PH_KEY_START;
          end else if (!is_ws(in_byte_r)) begin
            res0.kind = KIND_VALUE;
            res0.ch   = in_byte_r;
            phase_nxt = PH_UNQUOTED;
          end
        end
        PH_UNQUOTED: begin
          if (in_byte_r == CH_COMMA) begin
            res0.kind = KIND_PAIR;
            phase_nxt = PH_KEY_START;
          end else if (is_ws(in_byte_r)) begin
            phase_nxt = PH_AFTER_VAL;
          end else begin
            res0.kind = KIND_VALUE;
            res0.ch   = in_byte_r;
          end
        end
        PH_QUOTED: begin
          if (in_byte_r == (quote_r ? CH_SQUOTE : CH_DQUOTE)) begin
            phase_nxt = PH_AFTER_VAL;
          end else begin
            res0.kind = KIND_VALUE;
            res0.ch   = in_byte_r;
          end
        end
        PH_AFTER_VAL: begin
          if (!is_ws(in_byte_r)) begin
            res0.kind = KIND_PAIR;
            if (in_byte_r == CH_COMMA) begin
              phase_nxt = PH_KEY_START;
            end else begin
              phase_nxt = PH_ERROR;
              err_nxt   = ERR_CONTENT;
            end
          end
        end
        PH_ERROR: begin
          phase_nxt = PH_ERROR;
        end
        default: begin
          if (is_alnum(in_byte_r)) begin
            res0.kind = KIND_KEY;
            res0.ch   = in_byte_r;
            phase_nxt = PH_KEY;
          end else if (!is_ws(in_byte_r)) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_KEY_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      phase_r  <= PH_START;
      quote_r  <= 1'b0;
      err_r    <= ERR_KEY_START;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (fire) begin
        out_v_r  <= 1'b1;
        pend_v_r <= two;
        phase_r  <= phase_nxt;
        quote_r  <= quote_nxt;
        err_r    <= err_nxt;
      end else if (pend_v_r && out_tready) begin
        pend_v_r <= 1'b0;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
    if (fire) begin
      out_res_r  <= res0;
      out_last_r <= !two;
    end else if (pend_v_r && out_tready) begin
      out_res_r  <= '{kind: KIND_ACCEPT, ch: 8'd0, err: ERR_KEY_START};
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_res_r.err, out_res_r.ch};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

  `include "key_value_list_tokenizer_assert.svh"

  `KVLT_ASSERT_IMP(a_pend_behind_pair, pend_v_r, out_v_r && out_tuser == KIND_PAIR && !out_tlast)
  `KVLT_ASSERT_IMP(a_pend_after_reset_phase, pend_v_r, phase_r == PH_START && !quote_r)
  `KVLT_ASSERT_IMP(a_open_run_only_pair, out_v_r && !out_tlast, pend_v_r)
  `KVLT_ASSERT_IMP(a_char_only_tokens,
    out_v_r && out_tuser != KIND_KEY && out_tuser != KIND_VALUE, out_tdata[7:0] == 8'd0)
  `KVLT_ASSERT_NXT(a_pend_drains, pend_v_r && out_tready,
    out_v_r && out_tuser == KIND_ACCEPT && out_tlast && !pend_v_r)

endmodule

// ===== verif/kvlt_token_checker.sv =====
// Token checker for the key/value list tokenizer: predicts and compares every result.
module kvlt_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kvlt_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    err_t       err;
    logic       last;
  } token_t;

  token_t     expected_tokens[$];
  phase_t     phase;
  err_t       first_err;
  logic       quote_single;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_letter_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  task automatic predict_tokens(input logic [7:0] c, input logic eot);
    token_t t;
    t.kind = KIND_NONE;
    t.ch   = 8'h00;
    t.err  = ERR_KEY_START;
    t.last = 1'b1;
    if (eot) begin
      case (phase)
        PH_START: t.kind = KIND_ACCEPT;
        PH_KEY_START: t.kind = KIND_REJECT;
        PH_KEY, PH_AFTER_KEY: begin
          t.kind = KIND_REJECT;
          t.err  = ERR_EQUALS;
        end
        PH_QUOTED: begin
          t.kind = KIND_REJECT;
          t.err  = ERR_QUOTE;
        end
        PH_AFTER_EQ, PH_UNQUOTED, PH_AFTER_VAL: begin
          expected_tokens.push_back('{KIND_PAIR, 8'h00, ERR_KEY_START, 1'b0});
          t.kind = KIND_ACCEPT;
        end
        default: begin
          t.kind = KIND_REJECT;
          t.err  = first_err;
        end
      endcase
      phase        = PH_START;
      quote_single = 1'b0;
    end else begin
      case (phase)
        PH_START, PH_KEY_START: begin
          if (!is_space(c)) begin
            if (is_letter_digit(c)) begin
              t.kind = KIND_KEY;
              t.ch   = c;
              phase  = PH_KEY;
            end else begin
              phase     = PH_ERROR;
              first_err = ERR_KEY_START;
            end
          end
        end
        PH_KEY: begin
          if (is_letter_digit(c) || c == CH_DASH || c == CH_UNDER) begin
            t.kind = KIND_KEY;
            t.ch   = c;
          end else if (is_space(c)) begin
            phase = PH_AFTER_KEY;
          end else if (c == CH_EQUALS) begin
            phase = PH_AFTER_EQ;
          end else begin
            phase     = PH_ERROR;
            first_err = ERR_EQUALS;
          end
        end
        PH_AFTER_KEY: begin
          if (c == CH_EQUALS) begin
            phase = PH_AFTER_EQ;
          end else if (!is_space(c)) begin
            phase     = PH_ERROR;
            first_err = ERR_EQUALS;
          end
        end
        PH_AFTER_EQ: begin
          if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_single = (c == CH_SQUOTE);
            phase        = PH_QUOTED;
          end else if (c == CH_COMMA) begin
            t.kind = KIND_PAIR;
            phase  = PH_KEY_START;
          end else if (!is_space(c)) begin
            t.kind = KIND_VALUE;
            t.ch   = c;
            phase  = PH_UNQUOTED;
          end
        end
        PH_UNQUOTED: begin
          if (c == CH_COMMA) begin
            t.kind = KIND_PAIR;
            phase  = PH_KEY_START;
          end else if (is_space(c)) begin
            phase = PH_AFTER_VAL;
          end else begin
            t.kind = KIND_VALUE;
            t.ch   = c;
          end
        end
        PH_QUOTED: begin
          if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
            phase = PH_AFTER_VAL;
          end else begin
            t.kind = KIND_VALUE;
            t.ch   = c;
          end
        end
        PH_AFTER_VAL: begin
          if (!is_space(c)) begin
            t.kind = KIND_PAIR;
            if (c == CH_COMMA) begin
              phase = PH_KEY_START;
            end else begin
              phase     = PH_ERROR;
              first_err = ERR_CONTENT;
            end
          end
        end
        default: ;
      endcase
    end
    expected_tokens.push_back(t);
  endtask

  always @(posedge clk) begin : watch
    token_t e;
    if (!rst_n) begin
      expected_tokens.delete();
      phase        = PH_START;
      first_err    = ERR_KEY_START;
      quote_single = 1'b0;
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tokens(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: kind %0d data %h last %b", out_tuser, out_tdata,
                 out_tlast);
          fail_count++;
        end else begin
          e = expected_tokens.pop_front();
          if (out_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== e.ch) begin
            $error("char_out: expected %h, got %h", e.ch, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[9:8] !== e.err) begin
            $error("error_code: expected %0d, got %0d", e.err, out_tdata[9:8]);
            fail_count++;
          end
          if (out_tdata[15:10] !== 6'd0) begin
            $error("tdata padding: expected 0, got %h", out_tdata[15:10]);
            fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last_of_run: expected %b, got %b", e.last, out_tlast);
            fail_count++;
          end
        end
      end
      pending = expected_tokens.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the key/value list tokenizer: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kvlt_pkg::*;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  int          items_sent = 0;
  int          burst_left = 0;
  logic [7:0]  text_buf[$];

  always #10 clk = ~clk;

  key_value_list_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  kvlt_token_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic push_byte(input logic [7:0] b, input logic eot);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic end_text();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0: return 8'(8'h30 + $urandom_range(0, 9));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    logic [7:0] c;
    c = 8'($urandom_range(8'h08, 8'h0D));
    return (c == 8'h08) ? 8'h20 : c;
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 11))
      0: return CH_COMMA;
      1: return CH_EQUALS;
      2: return CH_DQUOTE;
      3: return CH_SQUOTE;
      4: return pick_space();
      5: return CH_DASH;
      6, 7: return pick_alnum();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_spaces(input int most);
    repeat ($urandom_range(0, most)) text_buf.push_back(pick_space());
  endtask

  task automatic add_pair();
    logic [7:0] c;
    logic [7:0] q;
    text_buf.push_back(pick_alnum());
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 7))
        0: text_buf.push_back(CH_DASH);
        1: text_buf.push_back(CH_UNDER);
        default: text_buf.push_back(pick_alnum());
      endcase
    end
    add_spaces(2);
    text_buf.push_back(CH_EQUALS);
    add_spaces(2);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        do c = 8'($urandom_range(8'h21, 8'hFF));
        while (c == CH_COMMA || c == CH_DQUOTE || c == CH_SQUOTE);
        text_buf.push_back(c);
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(8'h21, 8'hFF)); while (c == CH_COMMA);
          text_buf.push_back(c);
        end
      end
      default: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        text_buf.push_back(q);
        repeat ($urandom_range(0, 6)) begin
          do c = ($urandom_range(0, 2) == 0) ? pick_noise() : 8'($urandom_range(0, 255));
          while (c == q);
          text_buf.push_back(c);
        end
        text_buf.push_back(q);
      end
    endcase
  endtask

  task automatic make_text();
    int style;
    int n;
    text_buf.delete();
    style = $urandom_range(0, 19);
    if (style >= 18) begin
      repeat ($urandom_range(0, 10)) text_buf.push_back(pick_noise());
    end else begin
      n = $urandom_range(0, 4);
      add_spaces(2);
      for (int p = 0; p < n; p++) begin
        if (p > 0) begin
          add_spaces(1);
          text_buf.push_back(CH_COMMA);
          add_spaces(1);
        end
        add_pair();
      end
      add_spaces(2);
      if (style >= 15) begin
        case ($urandom_range(0, 2))
          0: text_buf.insert($urandom_range(0, text_buf.size()), pick_noise());
          1: begin
            n = $urandom_range(0, text_buf.size());
            while (text_buf.size() > n) void'(text_buf.pop_back());
          end
          default: text_buf.push_back(CH_COMMA);
        endcase
      end
    end
  endtask

  initial begin : stall_pattern
    int       cyc;
    int       hold;
    rx_mode_t mode;
    cyc  = 0;
    hold = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (cyc == 900 || cyc == 2500) hold = 300;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_HALF: out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    end_text();
    push_str(" \t");
    end_text();
    push_str("a=,");
    end_text();
    push_str("z_-=\"");
    push_byte(8'h00, 1'b0);
    end_text();
    push_str("9 'x");
    end_text();
    push_str("a='");
    push_byte(8'hFF, 1'b0);
    push_str("'b");
    end_text();
    push_str("#");
    end_text();
    push_str("A=b");
    end_text();

    while (items_sent < 1930) begin
      make_text();
      foreach (text_buf[i]) push_byte(text_buf[i], 1'b0);
      end_text();
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kvlt_pkg.sv
hw/rtl/key_value_list_tokenizer.sv
verif/kvlt_token_checker.sv
verif/testbench.sv
